// ----- sv/rssm_pkg.sv -----
`default_nettype none

package rssm_pkg;

    // Pool sizing
    localparam int NUM_READERS = 4;
    localparam int NUM_WRITERS = 2;
    localparam int SLOT_COUNT  = 9;
    localparam int DATA_WIDTH  = 64;

    // Derived widths; a count holds the writer plus every reader, and one more
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int RSEL_W = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;
    localparam int CNT_W  = $clog2(NUM_READERS + 2);

    // Request kinds
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [DATA_WIDTH-1:0] data_t;

    typedef struct packed {
        logic        req_type;
        logic [1:0]  reader_id;
        logic [63:0] write_data;
    } req_word_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic [3:0]  slot_index;
        logic        no_free_slot;
    } rsp_word_t;

    // Sequencer to scan unit
    typedef struct packed {
        logic  start;
        slot_t start_slot;
    } scan_ctl_t;

    // Scan unit to sequencer
    typedef struct packed {
        logic  found;
        logic  fail;
        slot_t slot;
    } scan_sts_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

endpackage

`default_nettype wire

// ----- sv/refcounted_snapshot_slot_manager.sv -----
`default_nettype none

// Channel   Direction  Handshake            Word
// req       in         req_valid/req_stall  rssm_pkg::req_word_t
// rsp       out        rsp_valid/rsp_stall  rssm_pkg::rsp_word_t
//
// A read passes through accept and commit. A write passes through accept, a scan of the
// slot busy bits by the scan unit (1 to SLOT_COUNT of them, one per cycle), and commit.
// Reset: slot 0 is current with all readers on it, all other slots free.
// The result sits in an output register; a stalled result only holds the commit step,
// and req_stall is high whenever a request is in progress.

module refcounted_snapshot_slot_manager
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  req_valid,
    output logic                 req_stall,
    input  rssm_pkg::req_word_t  req,
    output logic                 rsp_valid,
    input  wire                  rsp_stall,
    output rssm_pkg::rsp_word_t  rsp
);

    localparam int SC = rssm_pkg::SLOT_COUNT;
    localparam int NR = rssm_pkg::NUM_READERS;

    rssm_pkg::state_t  state_reg;
    rssm_pkg::state_t  state_next;

    // Latched request
    logic                        type_reg;
    logic [1:0]                  rid_reg;
    rssm_pkg::data_t             wdata_reg;
    logic                        fail_reg;
    rssm_pkg::slot_t             new_slot_reg;

    // Pool state
    rssm_pkg::slot_t             cur_reg;
    rssm_pkg::cnt_t              count_reg;
    rssm_pkg::slot_t             hint_reg;
    logic                        hint_valid_reg;
    logic [SC-1:0]               busy_reg;
    rssm_pkg::cnt_t              started_reg [SC];
    rssm_pkg::cnt_t              ended_reg   [SC];
    rssm_pkg::data_t             data_reg    [SC];
    rssm_pkg::slot_t             rslot_reg   [NR];

    rssm_pkg::rsp_word_t         rsp_reg;
    logic                        rsp_valid_reg;

    rssm_pkg::scan_ctl_t         scan_ctl;
    rssm_pkg::scan_sts_t         scan_sts;

    logic                        accept;
    logic                        out_free;
    logic                        commit;
    logic                        is_write;
    logic                        do_write;
    logic                        rd_in_range;
    logic [rssm_pkg::RSEL_W-1:0] rsel;
    rssm_pkg::slot_t             mine;
    logic                        do_release;
    rssm_pkg::slot_t             leave_slot;
    rssm_pkg::cnt_t              leave_started;
    rssm_pkg::cnt_t              ended_inc;
    logic                        leave_frees;
    rssm_pkg::slot_t             cur_plus1;
    rssm_pkg::rsp_word_t         rsp_new;

    assign accept   = req_valid && !req_stall;
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign is_write = (type_reg == rssm_pkg::REQ_WRITE);
    assign do_write = commit && is_write && !fail_reg;

    // Scan unit
    assign cur_plus1 = (cur_reg == rssm_pkg::slot_t'(SC - 1)) ? '0
                       : cur_reg + rssm_pkg::slot_t'(1);
    assign scan_ctl.start      = accept && (req.req_type == rssm_pkg::REQ_WRITE);
    assign scan_ctl.start_slot = hint_valid_reg ? hint_reg : cur_plus1;

    rssm_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .busy  (busy_reg),
        .sts   (scan_sts)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rssm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.req_type == rssm_pkg::REQ_WRITE) ? rssm_pkg::ST_SCAN
                                                                        : rssm_pkg::ST_COMMIT;
                end
            end
            rssm_pkg::ST_SCAN:
            begin
                if (scan_sts.found || scan_sts.fail)
                begin
                    state_next = rssm_pkg::ST_COMMIT;
                end
            end
            rssm_pkg::ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = rssm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rssm_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        req_stall = 1'b1;
        commit    = 1'b0;
        case (state_reg)
            rssm_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            rssm_pkg::ST_SCAN:
            begin
                req_stall = 1'b1;
            end
            rssm_pkg::ST_COMMIT:
            begin
                commit = out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rssm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Latch the request word and the scan outcome
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg  <= req.req_type;
            rid_reg   <= req.reader_id;
            wdata_reg <= req.write_data[rssm_pkg::DATA_WIDTH-1:0];
            fail_reg  <= 1'b0;
        end
        else if (state_reg == rssm_pkg::ST_SCAN)
        begin
            fail_reg     <= scan_sts.fail;
            new_slot_reg <= scan_sts.slot;
        end
    end

    // Reader lookup
    assign rsel        = rid_reg[rssm_pkg::RSEL_W-1:0];
    assign rd_in_range = (32'(rid_reg) < NR);
    assign mine        = rslot_reg[rsel];
    assign do_release  = commit && !is_write && rd_in_range && (mine != cur_reg);

    // Shared leave step: one reference leaves a retired slot
    assign leave_slot    = is_write ? cur_reg : mine;
    assign leave_started = is_write ? count_reg : started_reg[mine];
    assign ended_inc     = ended_reg[leave_slot] + rssm_pkg::cnt_t'(1);
    assign leave_frees   = (ended_inc == leave_started);

    // Update counts, busy bits and reader slots at commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg        <= '0;
            count_reg      <= rssm_pkg::cnt_t'(NR);
            hint_reg       <= '0;
            hint_valid_reg <= 1'b0;
            busy_reg       <= SC'(1);
            for (int i = 0; i < SC; i++)
            begin
                started_reg[i] <= '0;
                ended_reg[i]   <= '0;
            end
            for (int i = 0; i < NR; i++)
            begin
                rslot_reg[i] <= '0;
            end
        end
        else
        begin
            if (scan_ctl.start)
            begin
                hint_valid_reg <= 1'b0;
            end
            if (do_write)
            begin
                busy_reg[new_slot_reg]    <= 1'b1;
                started_reg[new_slot_reg] <= '0;
                ended_reg[new_slot_reg]   <= '0;
                cur_reg                   <= new_slot_reg;
                count_reg                 <= rssm_pkg::cnt_t'(1);
                started_reg[cur_reg]      <= count_reg;
                ended_reg[cur_reg]        <= ended_inc;
                if (leave_frees)
                begin
                    busy_reg[cur_reg] <= 1'b0;
                end
            end
            if (do_release)
            begin
                ended_reg[mine] <= ended_inc;
                if (leave_frees)
                begin
                    busy_reg[mine] <= 1'b0;
                    hint_reg       <= mine;
                    hint_valid_reg <= 1'b1;
                end
                count_reg       <= count_reg + rssm_pkg::cnt_t'(1);
                rslot_reg[rsel] <= cur_reg;
            end
        end
    end

    // Slot data: clear at reset so slot 0 starts at zero, store the new word at commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SC; i++)
            begin
                data_reg[i] <= '0;
            end
        end
        else if (do_write)
        begin
            data_reg[new_slot_reg] <= wdata_reg;
        end
    end

    // Form the result word
    always_comb
    begin
        rsp_new.read_data    = 64'(data_reg[cur_reg]);
        rsp_new.slot_index   = 4'(cur_reg);
        rsp_new.no_free_slot = 1'b0;
        if (is_write)
        begin
            if (fail_reg)
            begin
                rsp_new.slot_index   = '0;
                rsp_new.no_free_slot = 1'b1;
            end
            else
            begin
                rsp_new.read_data  = 64'(wdata_reg);
                rsp_new.slot_index = 4'(new_slot_reg);
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            rsp_reg <= rsp_new;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ----- sv/rssm_scan.sv -----
`default_nettype none

module rssm_scan
(
    input  wire                             clk,
    input  wire                             rst_n,
    input  rssm_pkg::scan_ctl_t             ctl,
    input  wire [rssm_pkg::SLOT_COUNT-1:0]  busy,
    output rssm_pkg::scan_sts_t             sts
);

    logic            run_reg;
    logic            run_next;
    rssm_pkg::slot_t probe_reg;
    rssm_pkg::slot_t probe_next;
    rssm_pkg::slot_t n_reg;
    rssm_pkg::slot_t n_next;
    logic            probe_busy;
    logic            last_probe;

    // Probe one busy bit per cycle
    assign probe_busy = busy[probe_reg];
    assign last_probe = (n_reg == rssm_pkg::slot_t'(rssm_pkg::SLOT_COUNT - 1));

    assign sts.found = run_reg && !probe_busy;
    assign sts.fail  = run_reg && probe_busy && last_probe;
    assign sts.slot  = probe_reg;

    // Advance the probe with wrap-around, stop on a hit or after a full lap
    always_comb
    begin
        run_next   = run_reg;
        probe_next = probe_reg;
        n_next     = n_reg;
        if (ctl.start)
        begin
            run_next   = 1'b1;
            probe_next = ctl.start_slot;
            n_next     = '0;
        end
        else if (run_reg)
        begin
            if (!probe_busy || last_probe)
            begin
                run_next = 1'b0;
            end
            else
            begin
                n_next = n_reg + rssm_pkg::slot_t'(1);
                if (probe_reg == rssm_pkg::slot_t'(rssm_pkg::SLOT_COUNT - 1))
                begin
                    probe_next = '0;
                end
                else
                begin
                    probe_next = probe_reg + rssm_pkg::slot_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
        n_reg     <= n_next;
    end

endmodule

`default_nettype wire
